FILE: sv/sle_pkg.sv
package sle_pkg;

   // Store geometry.
   localparam int CAPACITY = 32;
   localparam int DATA_W   = 32;
   localparam int ADDR_W   = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int CNT_W    = $clog2(CAPACITY + 1);

   // Field widths of the command and result beats.
   localparam int CMD_W    = 3;
   localparam int POS_W    = 6;
   localparam int LEN_W    = 6;
   localparam int STATUS_W = 2;

   // Width for comparing positions against the entry count.
   localparam int WIDE_W   = ((CNT_W > POS_W) ? CNT_W : POS_W) + 1;

   typedef logic [DATA_W-1:0] data_type;
   typedef logic [ADDR_W-1:0] addr_type;
   typedef logic [CNT_W-1:0]  cnt_type;
   typedef logic [POS_W-1:0]  pos_type;
   typedef logic [LEN_W-1:0]  len_type;
   typedef logic [WIDE_W-1:0] wide_type;

   typedef enum logic [CMD_W-1:0] {
      CMD_INSERT = 3'd0,
      CMD_ERASE  = 3'd1,
      CMD_GET    = 3'd2,
      CMD_LOCATE = 3'd3,
      CMD_CLEAR  = 3'd4
   } cmd_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_OK     = 2'd0,
      ST_FULL   = 2'd1,
      ST_BADPOS = 2'd2,
      ST_EMPTY  = 2'd3
   } status_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_INS_SHIFT,
      S_INS_LAST,
      S_ERA_SHIFT,
      S_GET_READ,
      S_GET_DATA,
      S_LOC
   } state_type;

   // One write port and one read port into the entry store.
   typedef struct packed {
      logic     wr_en;
      addr_type wr_addr;
      data_type wr_data;
      logic     rd_en;
      addr_type rd_addr;
   } mem_req_type;

endpackage

FILE: sv/sle_store.sv
module sle_store (
   input  logic                  clock,
   input  sle_pkg::mem_req_type  mem_req,
   output sle_pkg::data_type     rd_data
);

   sle_pkg::data_type entry_mem [sle_pkg::CAPACITY];
   sle_pkg::data_type rd_data_ff;

   // Write port.
   always_ff @(posedge clock) begin
      if (mem_req.wr_en) begin
         entry_mem[mem_req.wr_addr] <= mem_req.wr_data;
      end
   end

   // Read port with registered data.
   always_ff @(posedge clock) begin
      if (mem_req.rd_en) begin
         rd_data_ff <= entry_mem[mem_req.rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: sv/sle_ctrl.sv
module sle_ctrl (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   output logic                        busy,
   input  logic [sle_pkg::CMD_W-1:0]   req_command,
   input  logic [sle_pkg::POS_W-1:0]   req_position,
   input  logic [sle_pkg::DATA_W-1:0]  req_item_value,
   output logic                        rsp_strobe,
   output logic [sle_pkg::STATUS_W-1:0] rsp_status,
   output logic [sle_pkg::DATA_W-1:0]  rsp_read_value,
   output logic [sle_pkg::LEN_W-1:0]   rsp_found_index,
   output logic [sle_pkg::LEN_W-1:0]   rsp_list_length,
   output logic                        rsp_empty_flag,
   output sle_pkg::mem_req_type        mem_req,
   input  sle_pkg::data_type           mem_rd_data
);

   sle_pkg::state_type  state_ff, state_in;
   sle_pkg::cnt_type    count_ff, count_in;
   sle_pkg::cnt_type    ptr_ff, ptr_in;
   sle_pkg::pos_type    pos_ff, pos_in;
   sle_pkg::data_type   val_ff, val_in;
   logic                pend_ff, pend_in;
   sle_pkg::addr_type   pend_addr_ff, pend_addr_in;
   logic                rsp_strobe_ff, rsp_strobe_in;
   sle_pkg::status_type rsp_status_ff, rsp_status_in;
   sle_pkg::data_type   rsp_read_ff, rsp_read_in;
   sle_pkg::len_type    rsp_found_ff, rsp_found_in;

   logic                accept;
   sle_pkg::wide_type   count_w, req_pos_w, pos_w, ptr_w;
   logic                list_full, list_empty;
   logic                ins_ok, era_ok, get_ok;
   logic                loc_match;

   // Shared conditions; the position and count bounds are compared at a common width.
   assign busy      = (state_ff != sle_pkg::S_IDLE);
   assign accept    = start && !busy;
   assign count_w   = sle_pkg::wide_type'(count_ff);
   assign req_pos_w = sle_pkg::wide_type'(req_position);
   assign pos_w     = sle_pkg::wide_type'(pos_ff);
   assign ptr_w     = sle_pkg::wide_type'(ptr_ff);
   assign list_full  = (count_w >= sle_pkg::wide_type'(sle_pkg::CAPACITY));
   assign list_empty = (count_ff == '0);
   assign ins_ok    = !list_full && (req_pos_w <= count_w);
   assign era_ok    = !list_empty && (req_pos_w < count_w);
   assign get_ok    = !list_empty && (req_position != '0) && (req_pos_w <= count_w);
   assign loc_match = pend_ff && (mem_rd_data == val_ff);

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         sle_pkg::S_IDLE: begin
            if (accept) begin
               case (req_command)
                  sle_pkg::CMD_INSERT: if (ins_ok) state_in = sle_pkg::S_INS_SHIFT;
                  sle_pkg::CMD_ERASE:  if (era_ok) state_in = sle_pkg::S_ERA_SHIFT;
                  sle_pkg::CMD_GET:    if (get_ok) state_in = sle_pkg::S_GET_READ;
                  sle_pkg::CMD_LOCATE: if (!list_empty) state_in = sle_pkg::S_LOC;
                  default:             state_in = sle_pkg::S_IDLE;
               endcase
            end
         end
         sle_pkg::S_INS_SHIFT: begin
            if (ptr_w <= pos_w) state_in = sle_pkg::S_INS_LAST;
         end
         sle_pkg::S_INS_LAST: state_in = sle_pkg::S_IDLE;
         sle_pkg::S_ERA_SHIFT: begin
            if (ptr_w >= count_w) state_in = sle_pkg::S_IDLE;
         end
         sle_pkg::S_GET_READ: state_in = sle_pkg::S_GET_DATA;
         sle_pkg::S_GET_DATA: state_in = sle_pkg::S_IDLE;
         sle_pkg::S_LOC: begin
            if (loc_match || (!pend_ff && (ptr_w >= count_w))) state_in = sle_pkg::S_IDLE;
         end
         default: state_in = sle_pkg::S_IDLE;
      endcase
   end

   // Datapath, memory accesses and the result beat.
   always_comb begin
      count_in      = count_ff;
      ptr_in        = ptr_ff;
      pos_in        = pos_ff;
      val_in        = val_ff;
      pend_in       = 1'b0;
      pend_addr_in  = pend_addr_ff;
      rsp_strobe_in = 1'b0;
      rsp_status_in = sle_pkg::ST_OK;
      rsp_read_in   = '0;
      rsp_found_in  = '0;
      mem_req.wr_en   = 1'b0;
      mem_req.wr_addr = pend_addr_ff;
      mem_req.wr_data = mem_rd_data;
      mem_req.rd_en   = 1'b0;
      mem_req.rd_addr = sle_pkg::addr_type'(ptr_ff);

      case (state_ff)
         sle_pkg::S_IDLE: begin
            if (accept) begin
               pos_in = req_position;
               val_in = req_item_value;
               case (req_command)
                  sle_pkg::CMD_INSERT: begin
                     ptr_in = count_ff;
                     if (list_full) begin
                        rsp_strobe_in = 1'b1;
                        rsp_status_in = sle_pkg::ST_FULL;
                     end else if (!ins_ok) begin
                        rsp_strobe_in = 1'b1;
                        rsp_status_in = sle_pkg::ST_BADPOS;
                     end
                  end
                  sle_pkg::CMD_ERASE: begin
                     ptr_in = sle_pkg::cnt_type'(req_pos_w + sle_pkg::wide_type'(1));
                     if (list_empty) begin
                        rsp_strobe_in = 1'b1;
                        rsp_status_in = sle_pkg::ST_EMPTY;
                     end else if (!era_ok) begin
                        rsp_strobe_in = 1'b1;
                        rsp_status_in = sle_pkg::ST_BADPOS;
                     end
                  end
                  sle_pkg::CMD_GET: begin
                     if (list_empty) begin
                        rsp_strobe_in = 1'b1;
                        rsp_status_in = sle_pkg::ST_EMPTY;
                     end else if (!get_ok) begin
                        rsp_strobe_in = 1'b1;
                        rsp_status_in = sle_pkg::ST_BADPOS;
                     end
                  end
                  sle_pkg::CMD_LOCATE: begin
                     ptr_in = '0;
                     if (list_empty) rsp_strobe_in = 1'b1;
                  end
                  sle_pkg::CMD_CLEAR: begin
                     count_in      = '0;
                     rsp_strobe_in = 1'b1;
                  end
                  default: rsp_strobe_in = 1'b1;
               endcase
            end
         end

         // Walk down from the top: read slot ptr-1, write it to ptr in the next cycle.
         sle_pkg::S_INS_SHIFT: begin
            mem_req.wr_en = pend_ff;
            if (ptr_w > pos_w) begin
               mem_req.rd_en   = 1'b1;
               mem_req.rd_addr = sle_pkg::addr_type'(ptr_ff - sle_pkg::cnt_type'(1));
               pend_in         = 1'b1;
               pend_addr_in    = sle_pkg::addr_type'(ptr_ff);
               ptr_in          = ptr_ff - sle_pkg::cnt_type'(1);
            end
         end

         // The opened slot takes the new value.
         sle_pkg::S_INS_LAST: begin
            mem_req.wr_en   = 1'b1;
            mem_req.wr_addr = sle_pkg::addr_type'(pos_ff);
            mem_req.wr_data = val_ff;
            count_in        = count_ff + sle_pkg::cnt_type'(1);
            rsp_strobe_in   = 1'b1;
         end

         // Walk up from the erased slot: read slot ptr, write it to ptr-1.
         sle_pkg::S_ERA_SHIFT: begin
            mem_req.wr_en = pend_ff;
            if (ptr_w < count_w) begin
               mem_req.rd_en   = 1'b1;
               mem_req.rd_addr = sle_pkg::addr_type'(ptr_ff);
               pend_in         = 1'b1;
               pend_addr_in    = sle_pkg::addr_type'(ptr_ff - sle_pkg::cnt_type'(1));
               ptr_in          = ptr_ff + sle_pkg::cnt_type'(1);
            end else begin
               count_in      = count_ff - sle_pkg::cnt_type'(1);
               rsp_strobe_in = 1'b1;
            end
         end

         sle_pkg::S_GET_READ: begin
            mem_req.rd_en   = 1'b1;
            mem_req.rd_addr = sle_pkg::addr_type'(pos_ff - sle_pkg::pos_type'(1));
         end

         sle_pkg::S_GET_DATA: begin
            rsp_strobe_in = 1'b1;
            rsp_read_in   = mem_rd_data;
         end

         // Read one entry a cycle and compare it the cycle after; stop at the first match.
         sle_pkg::S_LOC: begin
            if (loc_match) begin
               rsp_strobe_in = 1'b1;
               rsp_found_in  = sle_pkg::len_type'(sle_pkg::wide_type'(pend_addr_ff)
                                                  + sle_pkg::wide_type'(1));
            end else if (ptr_w < count_w) begin
               mem_req.rd_en   = 1'b1;
               mem_req.rd_addr = sle_pkg::addr_type'(ptr_ff);
               pend_in         = 1'b1;
               pend_addr_in    = sle_pkg::addr_type'(ptr_ff);
               ptr_in          = ptr_ff + sle_pkg::cnt_type'(1);
            end else if (!pend_ff) begin
               rsp_strobe_in = 1'b1;
            end
         end

         default: begin
            rsp_strobe_in = 1'b0;
         end
      endcase
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= sle_pkg::S_IDLE;
         count_ff      <= '0;
         pend_ff       <= 1'b0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         count_ff      <= count_in;
         pend_ff       <= pend_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      ptr_ff        <= ptr_in;
      pos_ff        <= pos_in;
      val_ff        <= val_in;
      pend_addr_ff  <= pend_addr_in;
      rsp_status_ff <= rsp_status_in;
      rsp_read_ff   <= rsp_read_in;
      rsp_found_ff  <= rsp_found_in;
   end

   // The count already holds its new value while the result beat is shown.
   assign rsp_strobe      = rsp_strobe_ff;
   assign rsp_status      = rsp_status_ff;
   assign rsp_read_value  = rsp_read_ff;
   assign rsp_found_index = rsp_found_ff;
   assign rsp_list_length = sle_pkg::len_type'(count_ff);
   assign rsp_empty_flag  = (count_ff == '0);

   // The entry count never passes the capacity.
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      sle_pkg::wide_type'(count_ff) <= sle_pkg::wide_type'(sle_pkg::CAPACITY))
      else $error("entry count above capacity");

   // A shift never reads the slot it writes in the same cycle.
   a_no_rw_collide: assert property (@(posedge clock) disable iff (reset)
      !(mem_req.wr_en && mem_req.rd_en && (mem_req.wr_addr == mem_req.rd_addr)))
      else $error("read and write to the same slot");

   // A result beat is shown only once the engine is idle again.
   a_strobe_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> !busy)
      else $error("result beat while busy");

   // No read is left in flight when an operation completes.
   a_pend_busy: assert property (@(posedge clock) disable iff (reset)
      pend_ff |-> busy)
      else $error("pending read while idle");

   // Only the count-changing commands move the count.
   a_count_change: assert property (@(posedge clock) disable iff (reset)
      (count_ff != $past(count_ff)) && !$past(reset) |-> rsp_strobe)
      else $error("count changed without a result beat");

endmodule

FILE: sv/sequential_list_engine.sv
// Ordered list of up to 32 signed words held in a single-port-read, single-port-write
// RAM with registered read data. A command beat is taken when start is high and
// busy is low; exactly one result beat follows, marked by rsp_strobe for one cycle, and
// the receiver cannot stall it. Clear, unknown codes, a locate on an empty list and
// every rejected command leave busy low. Erase at slot p shifts the entries above p
// down, insert at slot p shifts the entries from p up, get reads one slot, and locate
// reads from slot 0 up to the first match or the end of the list. The longest command
// is a locate with no match over a full list. Shifts and searches move one entry per
// cycle, bounded by the single RAM read port. busy drops in the cycle that shows the
// result, so the next command can be taken there. list_length and empty_flag give the
// state after the command.
module sequential_list_engine (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   output logic                         busy,
   input  logic [2:0]                   req_command,
   input  logic [5:0]                   req_position,
   input  logic signed [31:0]           req_item_value,
   output logic                         rsp_strobe,
   output logic [1:0]                   rsp_status,
   output logic signed [31:0]           rsp_read_value,
   output logic [5:0]                   rsp_found_index,
   output logic [5:0]                   rsp_list_length,
   output logic                         rsp_empty_flag
);

   sle_pkg::mem_req_type mem_req;
   sle_pkg::data_type    mem_rd_data;

   // Command sequencer and result register.
   sle_ctrl u_ctrl (
      .clock           (clock),
      .reset           (reset),
      .start           (start),
      .busy            (busy),
      .req_command     (req_command),
      .req_position    (req_position),
      .req_item_value  (req_item_value),
      .rsp_strobe      (rsp_strobe),
      .rsp_status      (rsp_status),
      .rsp_read_value  (rsp_read_value),
      .rsp_found_index (rsp_found_index),
      .rsp_list_length (rsp_list_length),
      .rsp_empty_flag  (rsp_empty_flag),
      .mem_req         (mem_req),
      .mem_rd_data     (mem_rd_data)
   );

   // Entry RAM.
   sle_store u_store (
      .clock   (clock),
      .mem_req (mem_req),
      .rd_data (mem_rd_data)
   );

endmodule
